FILE: rtl/ccp_pkg.sv
// shared types and constants for the coefficient compress and pack block
package ccp_pkg;

  localparam int unsigned D_W      = 4;   // width of bits_per_coeff
  localparam int unsigned Q_W      = 14;  // width of modulus
  localparam int unsigned DMAX     = 11;  // widest compressed value
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PEND_W   = 7;   // leftover bits between items
  localparam int unsigned PCNT_W   = 3;
  localparam int unsigned ACC_W    = PEND_W + DMAX;
  localparam int unsigned ACNT_W   = 5;   // holds up to ACC_W
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = Q_W;

  localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_COEFF = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS        = 1'd1;

  localparam logic [D_W-1:0] D_RESET = 4'd10;
  localparam logic [Q_W-1:0] Q_RESET = 14'd7681;

  localparam logic [D_W-1:0] D_9  = 4'd9;
  localparam logic [D_W-1:0] D_10 = 4'd10;
  localparam logic [D_W-1:0] D_11 = 4'd11;

  localparam logic [DMAX-1:0] MASK_9  = 11'h1ff;
  localparam logic [DMAX-1:0] MASK_10 = 11'h3ff;
  localparam logic [DMAX-1:0] MASK_11 = 11'h7ff;

  // per-item flags worked out by the front end
  typedef struct packed {
    logic last;
    logic supported;
    logic q_zero;
  } cmd_flags_t;

  typedef struct packed {
    logic                final_byte;
    logic [BYTE_W-1:0]   packed_byte;
  } out_item_t;

  function automatic logic [DMAX-1:0] d_mask(input logic [D_W-1:0] d);
    logic [DMAX-1:0] m;
    unique case (d)
      D_9:     m = MASK_9;
      D_10:    m = MASK_10;
      D_11:    m = MASK_11;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/ccp_fifo.sv
// small register queue used between the front end, the packer and the result port
module ccp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/ccp_front.sv
// front end: configuration registers and classification of incoming items
module ccp_front #(
  parameter int unsigned COEFF_WIDTH = 14
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ccp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ccp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            push_i,
  input  logic [COEFF_WIDTH-1:0]          coefficient_i,
  input  logic                            final_coeff_i,
  output logic                            cmd_push_o,
  output logic [COEFF_WIDTH-1:0]          cmd_coeff_o,
  output ccp_pkg::cmd_flags_t             cmd_flags_o,
  output logic [ccp_pkg::D_W-1:0]         bits_per_coeff_o,
  output logic [ccp_pkg::Q_W-1:0]         modulus_o
);
  import ccp_pkg::*;

  logic [D_W-1:0] d_q;
  logic [Q_W-1:0] q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_q <= D_RESET;
      q_q <= Q_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BITS_PER_COEFF: d_q <= cfg_data_i[D_W-1:0];
        CFG_MODULUS:        q_q <= cfg_data_i[Q_W-1:0];
        default:            ;
      endcase
    end
  end

  assign bits_per_coeff_o = d_q;
  assign modulus_o        = q_q;

  assign cmd_push_o            = push_i;
  assign cmd_coeff_o           = coefficient_i;
  assign cmd_flags_o.last      = final_coeff_i;
  assign cmd_flags_o.supported = (d_q == D_9) || (d_q == D_10) || (d_q == D_11);
  assign cmd_flags_o.q_zero    = (q_q == '0);

endmodule

FILE: rtl/ccp_div.sv
// restoring divider, one quotient bit per cycle
module ccp_div #(
  parameter int unsigned NUM_W = 26,
  parameter int unsigned DEN_W = 14
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);
  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             run_q, run_d, done_q, done_d;
  logic [DEN_W:0]   trial, diff;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = num_i;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      // no borrow means the divisor fits
      if (!diff[DEN_W]) begin
        rem_d = diff[DEN_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DEN_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: rtl/ccp_packer.sv
// back end: quantizes one item and packs its bits into bytes
module ccp_packer #(
  parameter int unsigned COEFF_WIDTH = 14
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_empty_i,
  output logic                       cmd_pop_o,
  input  logic [COEFF_WIDTH-1:0]     cmd_coeff_i,
  input  ccp_pkg::cmd_flags_t        cmd_flags_i,
  input  logic [ccp_pkg::D_W-1:0]    bits_per_coeff_i,
  input  logic [ccp_pkg::Q_W-1:0]    modulus_i,
  output logic                       byte_push_o,
  output ccp_pkg::out_item_t         byte_item_o,
  input  logic                       byte_full_i
);
  import ccp_pkg::*;

  localparam int unsigned NUM_W = COEFF_WIDTH + DMAX + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [PEND_W-1:0] pend_q, pend_d;
  logic [PCNT_W-1:0] pcnt_q, pcnt_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [ACNT_W-1:0] cnt_q, cnt_d;
  logic              last_q, last_d;

  logic              div_start, div_done;
  logic [NUM_W-1:0]  num, quo;
  logic [DMAX-1:0]   mask;
  logic [ACC_W-1:0]  merged_div, merged_max;
  logic [ACNT_W-1:0] cnt_new;

  assign mask = d_mask(bits_per_coeff_i);
  // x * 2^d + floor(q / 2)
  assign num  = (NUM_W'(cmd_coeff_i) << bits_per_coeff_i) + NUM_W'(modulus_i >> 1);

  ccp_div #(
    .NUM_W (NUM_W),
    .DEN_W (Q_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (modulus_i),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // new bits go in above the leftover ones
  assign merged_div = ACC_W'(pend_q) | (ACC_W'(quo[DMAX-1:0] & mask) << pcnt_q);
  assign merged_max = ACC_W'(pend_q) | (ACC_W'(mask) << pcnt_q);
  assign cnt_new    = ACNT_W'(pcnt_q) + ACNT_W'(bits_per_coeff_i);

  always_comb begin
    state_d     = state_q;
    pend_d      = pend_q;
    pcnt_d      = pcnt_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    cmd_pop_o   = 1'b0;
    div_start   = 1'b0;
    byte_push_o = 1'b0;
    byte_item_o.packed_byte = acc_q[BYTE_W-1:0];
    byte_item_o.final_byte  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          last_d    = cmd_flags_i.last;
          if (!cmd_flags_i.supported) begin
            // dropped item; a last one still clears the leftover bits
            if (cmd_flags_i.last) begin
              pend_d = '0;
              pcnt_d = '0;
            end
          end else if (cmd_flags_i.q_zero) begin
            acc_d   = merged_max;
            cnt_d   = cnt_new;
            state_d = ST_EMIT;
          end else begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          acc_d   = merged_div;
          cnt_d   = cnt_new;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (cnt_q >= ACNT_W'(BYTE_W)) begin
          byte_push_o            = 1'b1;
          byte_item_o.final_byte = last_q && (cnt_q == ACNT_W'(BYTE_W));
          if (!byte_full_i) begin
            acc_d = acc_q >> BYTE_W;
            cnt_d = cnt_q - ACNT_W'(BYTE_W);
          end
        end else if (last_q && (cnt_q != '0)) begin
          // zero-padded flush byte
          byte_push_o            = 1'b1;
          byte_item_o.final_byte = 1'b1;
          if (!byte_full_i) begin
            acc_d = '0;
            cnt_d = '0;
          end
        end else begin
          pend_d  = acc_q[PEND_W-1:0];
          pcnt_d  = cnt_q[PCNT_W-1:0];
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= '0;
      pcnt_q  <= '0;
      cnt_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      pcnt_q  <= pcnt_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

endmodule

FILE: rtl/coefficient_compress_pack.sv
// top level: compresses coefficients to d bits and packs them lsb first into bytes
//
//   channel   direction  ports                                 handshake
//   config    in         cfg_we_i cfg_idx_i cfg_data_i         write on cfg_we_i
//   input     in         coefficient_i final_coeff_i           push && !full
//   result    out        packed_byte_o final_byte_o            pop && !empty
//
// an item with d of 9 to 11 and a nonzero modulus holds the back end while it is
// taken, divided (the quotient built bit by bit, then handed over), emitted one byte
// at a time and closed; a zero modulus skips the divider, and a dropped item is
// popped and discarded without leaving the idle state.
// a two-entry queue on each side lets input and result stall on their own.
// reset is asynchronous and active low; it loads the register defaults.
module coefficient_compress_pack #(
  parameter int unsigned COEFF_WIDTH = 14
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ccp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ccp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            push,
  output logic                            full,
  input  logic [COEFF_WIDTH-1:0]          coefficient_i,
  input  logic                            final_coeff_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [ccp_pkg::BYTE_W-1:0]      packed_byte_o,
  output logic                            final_byte_o
);
  import ccp_pkg::*;

  localparam int unsigned CMD_W = COEFF_WIDTH + $bits(cmd_flags_t);
  localparam int unsigned OUT_W = $bits(out_item_t);

  logic                   cmd_push, cmd_pop, cmd_empty;
  logic [COEFF_WIDTH-1:0] front_coeff, cmd_coeff;
  cmd_flags_t             front_flags, cmd_flags;
  logic [CMD_W-1:0]       cmd_wdata, cmd_rdata;
  logic [D_W-1:0]         bits_per_coeff;
  logic [Q_W-1:0]         modulus;
  logic                   byte_push, byte_full;
  out_item_t              byte_item, out_item;
  logic [OUT_W-1:0]       out_rdata;

  ccp_front #(
    .COEFF_WIDTH (COEFF_WIDTH)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .push_i           (push),
    .coefficient_i    (coefficient_i),
    .final_coeff_i    (final_coeff_i),
    .cmd_push_o       (cmd_push),
    .cmd_coeff_o      (front_coeff),
    .cmd_flags_o      (front_flags),
    .bits_per_coeff_o (bits_per_coeff),
    .modulus_o        (modulus)
  );

  assign cmd_wdata = {front_coeff, front_flags};

  ccp_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_wdata),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_rdata),
    .empty_o (cmd_empty)
  );

  assign cmd_coeff = cmd_rdata[CMD_W-1 -: COEFF_WIDTH];
  assign cmd_flags = cmd_flags_t'(cmd_rdata[$bits(cmd_flags_t)-1:0]);

  ccp_packer #(
    .COEFF_WIDTH (COEFF_WIDTH)
  ) u_packer (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_empty_i      (cmd_empty),
    .cmd_pop_o        (cmd_pop),
    .cmd_coeff_i      (cmd_coeff),
    .cmd_flags_i      (cmd_flags),
    .bits_per_coeff_i (bits_per_coeff),
    .modulus_i        (modulus),
    .byte_push_o      (byte_push),
    .byte_item_o      (byte_item),
    .byte_full_i      (byte_full)
  );

  ccp_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (2)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (byte_push),
    .data_i  (byte_item),
    .full_o  (byte_full),
    .pop_i   (pop),
    .data_o  (out_rdata),
    .empty_o (empty)
  );

  assign out_item      = out_item_t'(out_rdata);
  assign packed_byte_o = out_item.packed_byte;
  assign final_byte_o  = out_item.final_byte;

endmodule

FILE: tb/coefficient_compress_pack_test.sv
// self-checking testbench for coefficient_compress_pack: directed table, then random vectors
module coefficient_compress_pack_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ccp_pkg::*;

  localparam int unsigned CW = 14;
  // two worst-case back-end items plus queue hops
  localparam int SETTLE = 2 * (CW + 18) + 8;
  localparam int LONG_HOLD = 300;
  localparam int ITEM_GOAL = 270;
  localparam int PREDICTED = -1;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CW-1:0]        value;
    logic                 fin;
    int                   n_typed;
    out_item_t [0:2]      typed;
  } stim_row_t;

  // byte lists, first byte leftmost: {final, byte} per entry
  localparam out_item_t [0:2] NO_BYTES  = '0;
  localparam out_item_t [0:2] ZERO_PAIR = {1'b0, 8'h00, 1'b1, 8'h00, 9'h000};
  localparam out_item_t [0:2] Q0_D11    = {1'b0, 8'hff, 1'b1, 8'h07, 9'h000};
  localparam out_item_t [0:2] Q0_D9     = {1'b0, 8'hff, 1'b1, 8'h01, 9'h000};

  stim_row_t dir_rows [39] = '{
    // reset settings: d 10, q 7681
    '{ROW_ITEM, 1'b0, 14'd0,      1'b1, 2,         ZERO_PAIR},
    '{ROW_ITEM, 1'b0, 14'd7680,   1'b0, PREDICTED, NO_BYTES},
    '{ROW_ITEM, 1'b0, 14'd16383,  1'b0, PREDICTED, NO_BYTES},
    '{ROW_ITEM, 1'b0, 14'd1,      1'b0, PREDICTED, NO_BYTES},
    '{ROW_ITEM, 1'b0, 14'd3840,   1'b1, PREDICTED, NO_BYTES},
    '{ROW_CFG,  CFG_BITS_PER_COEFF, 14'd9, 1'b0, 0, NO_BYTES},
    '{ROW_ITEM, 1'b0, 14'd16383,  1'b0, PREDICTED, NO_BYTES},
    '{ROW_ITEM, 1'b0, 14'h2aaa,   1'b0, PREDICTED, NO_BYTES},
    '{ROW_ITEM, 1'b0, 14'h1555,   1'b1, PREDICTED, NO_BYTES},
    '{ROW_CFG,  CFG_BITS_PER_COEFF, 14'd11, 1'b0, 0, NO_BYTES},
    '{ROW_ITEM, 1'b0, 14'd7681,   1'b0, PREDICTED, NO_BYTES},
    '{ROW_ITEM, 1'b0, 14'd5000,   1'b0, PREDICTED, NO_BYTES},
    '{ROW_ITEM, 1'b0, 14'd16383,  1'b1, PREDICTED, NO_BYTES},
    // zero modulus saturates the quotient
    '{ROW_CFG,  CFG_MODULUS, 14'd0, 1'b0, 0, NO_BYTES},
    '{ROW_ITEM, 1'b0, 14'd123,    1'b1, 2,         Q0_D11},
    '{ROW_CFG,  CFG_BITS_PER_COEFF, 14'd9, 1'b0, 0, NO_BYTES},
    '{ROW_ITEM, 1'b0, 14'd0,      1'b1, 2,         Q0_D9},
    '{ROW_CFG,  CFG_MODULUS, 14'd2, 1'b0, 0, NO_BYTES},
    '{ROW_CFG,  CFG_BITS_PER_COEFF, 14'd10, 1'b0, 0, NO_BYTES},
    '{ROW_ITEM, 1'b0, 14'd16383,  1'b0, PREDICTED, NO_BYTES},
    '{ROW_ITEM, 1'b0, 14'd1,      1'b1, PREDICTED, NO_BYTES},
    '{ROW_CFG,  CFG_MODULUS, 14'd16383, 1'b0, 0, NO_BYTES},
    '{ROW_ITEM, 1'b0, 14'd16383,  1'b0, PREDICTED, NO_BYTES},
    '{ROW_ITEM, 1'b0, 14'd8192,   1'b1, PREDICTED, NO_BYTES},
    // unsupported widths drop the item
    '{ROW_CFG,  CFG_BITS_PER_COEFF, 14'd0, 1'b0, 0, NO_BYTES},
    '{ROW_ITEM, 1'b0, 14'd100,    1'b0, 0,         NO_BYTES},
    '{ROW_ITEM, 1'b0, 14'd16383,  1'b1, 0,         NO_BYTES},
    '{ROW_CFG,  CFG_BITS_PER_COEFF, 14'd15, 1'b0, 0, NO_BYTES},
    '{ROW_ITEM, 1'b0, 14'd5,      1'b1, 0,         NO_BYTES},
    '{ROW_CFG,  CFG_BITS_PER_COEFF, 14'd8, 1'b0, 0, NO_BYTES},
    '{ROW_ITEM, 1'b0, 14'd5,      1'b0, 0,         NO_BYTES},
    '{ROW_CFG,  CFG_BITS_PER_COEFF, 14'd12, 1'b0, 0, NO_BYTES},
    '{ROW_ITEM, 1'b0, 14'd5,      1'b0, 0,         NO_BYTES},
    // leftover bits cleared by a final item at an unsupported width
    '{ROW_CFG,  CFG_BITS_PER_COEFF, 14'd10, 1'b0, 0, NO_BYTES},
    '{ROW_ITEM, 1'b0, 14'd9,      1'b0, PREDICTED, NO_BYTES},
    '{ROW_CFG,  CFG_BITS_PER_COEFF, 14'd12, 1'b0, 0, NO_BYTES},
    '{ROW_ITEM, 1'b0, 14'd7,      1'b1, 0,         NO_BYTES},
    '{ROW_CFG,  CFG_BITS_PER_COEFF, 14'd10, 1'b0, 0, NO_BYTES},
    '{ROW_ITEM, 1'b0, 14'd0,      1'b1, 2,         ZERO_PAIR}
  };

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  push          = 1'b0;
  logic                  full;
  logic [CW-1:0]         coefficient_i = '0;
  logic                  final_coeff_i = 1'b0;
  logic                  empty;
  logic                  pop           = 1'b0;
  logic [BYTE_W-1:0]     packed_byte_o;
  logic                  final_byte_o;

  // predictor state and settings
  logic [D_W-1:0]    cur_d     = D_RESET;
  logic [Q_W-1:0]    cur_q     = Q_RESET;
  logic [PEND_W-1:0] held_bits = '0;
  logic [PCNT_W-1:0] held_cnt  = '0;
  out_item_t         step_out [0:2];
  int                step_n;

  out_item_t byte_q [$];
  int        errors = 0;
  int        sent_coeffs = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  bit        long_hold_req = 1'b0;
  int        stall_left = 0;

  coefficient_compress_pack #(.COEFF_WIDTH(CW)) u_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .push,
    .full,
    .coefficient_i,
    .final_coeff_i,
    .empty,
    .pop,
    .packed_byte_o,
    .final_byte_o
  );

  always #5ns clk_i = ~clk_i;

  // quantize one coefficient, append it to the held bits, split off whole bytes, flush if final
  function automatic void pack_coeff(input logic [CW-1:0] x, input logic fin);
    logic [31:0] mask;
    logic [31:0] num;
    logic [31:0] qv;
    logic [31:0] acc;
    int          cnt;
    step_n = 0;
    if (cur_d < D_9 || cur_d > D_11) begin
      if (fin) begin
        held_bits = '0;
        held_cnt  = '0;
      end
      return;
    end
    mask = (32'd1 << cur_d) - 32'd1;
    if (cur_q == '0) begin
      qv = mask;
    end else begin
      num = (32'(x) << cur_d) + 32'(cur_q >> 1);
      qv  = (num / 32'(cur_q)) & mask;
    end
    acc = 32'(held_bits) | (qv << held_cnt);
    cnt = int'(held_cnt) + int'(cur_d);
    while (cnt >= 8) begin
      step_out[step_n] = {1'b0, acc[7:0]};
      step_n++;
      acc >>= 8;
      cnt -= 8;
    end
    if (fin) begin
      if (cnt > 0) begin
        step_out[step_n] = {1'b0, acc[7:0]};
        step_n++;
      end
      step_out[step_n-1].final_byte = 1'b1;
      acc = '0;
      cnt = 0;
    end
    held_bits = PEND_W'(acc);
    held_cnt  = PCNT_W'(cnt);
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 100) $display("%0t mismatch: %s", $realtime, what);
  endtask

  task automatic take_byte();
    out_item_t want;
    if (byte_q.size() == 0) begin
      report_mismatch($sformatf("unexpected byte %02h final %0b", packed_byte_o, final_byte_o));
      return;
    end
    want = byte_q.pop_front();
    if (packed_byte_o !== want.packed_byte)
      report_mismatch($sformatf("packed_byte %02h, want %02h", packed_byte_o, want.packed_byte));
    if (final_byte_o !== want.final_byte)
      report_mismatch($sformatf("final_byte %0b, want %0b on byte %02h",
                                final_byte_o, want.final_byte, want.packed_byte));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_BITS_PER_COEFF) cur_d = data[D_W-1:0];
    else cur_q = data[Q_W-1:0];
    @(posedge clk_i);
  endtask

  task automatic wait_drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (byte_q.size() != 0) @(posedge clk_i);
  endtask

  // dropped items leave no bytes behind, so give them time to pass too
  task automatic wait_idle();
    wait_drain();
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic offer_coeff(input logic [CW-1:0] x, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      push          <= 1'b0;
      coefficient_i <= CW'($urandom);
      final_coeff_i <= $urandom_range(1);
      @(posedge clk_i);
    end
    push          <= 1'b1;
    coefficient_i <= x;
    final_coeff_i <= fin;
    @(negedge clk_i);
    while (full) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic send_coeff(input logic [CW-1:0] x, input logic fin);
    offer_coeff(x, fin);
    pack_coeff(x, fin);
    for (int i = 0; i < step_n; i++) byte_q.push_back(step_out[i]);
    sent_coeffs++;
  endtask

  function automatic logic [CW-1:0] pick_coeff(input bit in_range);
    logic [CW-1:0] c;
    c = CW'($urandom);
    if (in_range && cur_q != '0) begin
      case ($urandom_range(9))
        0:       c = '0;
        1:       c = CW'(cur_q - 1'b1);
        default: c = CW'($urandom_range(int'(cur_q) - 1, 0));
      endcase
    end
    return c;
  endfunction

  task automatic random_config();
    logic [D_W-1:0] d;
    logic [Q_W-1:0] q;
    if ($urandom_range(9) < 8) begin
      d = D_9 + D_W'($urandom_range(2));
    end else begin
      do d = D_W'($urandom_range(15)); while (d >= D_9 && d <= D_11);
    end
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0:       q = '0;
          1:       q = Q_W'(1);
          2:       q = Q_W'(2);
          default: q = '1;
        endcase
      end
      1:       q = Q_RESET;
      2:       q = Q_W'(3329);
      default: q = Q_W'($urandom_range(16383, 2));
    endcase
    // upper data bits are don't-care for the width register
    write_reg(CFG_BITS_PER_COEFF, {(CFG_DATA_W-D_W)'($urandom), d});
    write_reg(CFG_MODULUS, q);
  endtask

  // one vector: mostly whole polynomials, sometimes ragged noise
  task automatic random_vector(input bit hold);
    bit well;
    int len;
    well = hold || ($urandom_range(9) < 7);
    len  = hold ? 32 : (well ? 8 * $urandom_range(4, 1) : $urandom_range(12, 1));
    for (int k = 0; k < len; k++) begin
      if (well) send_coeff(pick_coeff(1'b1), k == len - 1);
      else send_coeff(pick_coeff(1'b0), $urandom_range(3) == 0);
    end
  endtask

  // result side
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        stall_left    = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
      @(negedge clk_i);
      if (rst_ni && pop && !empty) take_byte();
    end
  end

  initial begin
    int  goal;
    bit  first;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(dir_rows[i].idx, dir_rows[i].value);
      end else if (dir_rows[i].n_typed == PREDICTED) begin
        send_coeff(dir_rows[i].value, dir_rows[i].fin);
      end else begin
        offer_coeff(dir_rows[i].value, dir_rows[i].fin);
        pack_coeff(dir_rows[i].value, dir_rows[i].fin);
        for (int j = 0; j < dir_rows[i].n_typed; j++) byte_q.push_back(dir_rows[i].typed[j]);
      end
    end
    wait_idle();
    sent_coeffs = 0;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      goal  = ITEM_GOAL * (phase + 1) / 4;
      first = 1'b1;
      while (sent_coeffs < goal) begin
        random_config();
        for (int v = $urandom_range(3, 1); v > 0 && sent_coeffs < goal; v--) begin
          // receiver stops long enough for the input side to fill
          if (first && phase == 0) begin
            if (cur_d < D_9 || cur_d > D_11) write_reg(CFG_BITS_PER_COEFF, CFG_DATA_W'(D_10));
            long_hold_req = 1'b1;
          end
          random_vector(first && phase == 0);
          if (first) begin
            wait_drain();
            first = 1'b0;
          end
        end
        wait_idle();
      end
    end

    if (errors == 0) begin
      $display("coefficient_compress_pack_test passed");
    end else begin
      $display("coefficient_compress_pack_test failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("coefficient_compress_pack_test failed");
    $finish;
  end

endmodule

FILE: coefficient_compress_pack.f
rtl/ccp_pkg.sv
rtl/ccp_fifo.sv
rtl/ccp_front.sv
rtl/ccp_div.sv
rtl/ccp_packer.sv
rtl/coefficient_compress_pack.sv
tb/coefficient_compress_pack_test.sv
